FILE: hw/rtl/vsc_pkg.sv
// Shared constants and types for the value-to-spectrum color unit.
// No dependencies; the divider, shade stage, top level and bench refer to it by scoped names.
package vsc_pkg;

  // Widths of the word fields.
  localparam int LEVEL_W      = 8;
  localparam int MAXV_W       = 8;
  localparam int CHANNEL_BITS = 8;

  // Reset value of the max_value register.
  localparam logic [MAXV_W-1:0] MAX_VALUE_RESET = 8'd30;

  // The wavelength offset above 400 nm is kept at 1/16 nm, so 300 nm is 4800 steps.
  localparam int WL_SPAN = 4800;

  // The offset is at most WL_SPAN, which fits in 13 quotient bits.
  localparam int Q_BITS     = 13;
  localparam int DIVIDEND_W = Q_BITS + MAXV_W;

  // Default depth of the divider pipeline.
  localparam int DIV_STAGES = 4;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic black;
  } tag_t;

endpackage

FILE: hw/rtl/vsc_divider.sv
// Pipelined restoring divider that forms the wavelength offset 4800*level/max_value.
// Depends on vsc_pkg for widths and the pipeline tag type.
module vsc_divider #(
  parameter int STAGES = vsc_pkg::DIV_STAGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vsc_pkg::tag_t               tag_i,
  input  logic [vsc_pkg::MAXV_W-1:0]  divisor_i,
  input  logic [vsc_pkg::MAXV_W-1:0]  rem_i,
  input  logic [vsc_pkg::Q_BITS-1:0]  dq_i,
  output vsc_pkg::tag_t               tag_o,
  output logic [vsc_pkg::Q_BITS-1:0]  quot_o
);

  localparam int QB  = vsc_pkg::Q_BITS;
  localparam int DW  = vsc_pkg::MAXV_W;
  localparam int SPS = (QB + STAGES - 1) / STAGES;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    vsc_pkg::tag_t st_tag;
    logic [DW-1:0] st_div;
    logic [DW-1:0] st_rem;
    logic [QB-1:0] st_dq;
    vsc_pkg::tag_t tag_r;
    logic [DW-1:0] div_r;
    logic [DW-1:0] rem_r;
    logic [QB-1:0] dq_r;
    logic [DW-1:0] rem_nxt;
    logic [QB-1:0] dq_nxt;

    if (s == 0) begin : g_first
      assign st_tag = tag_i;
      assign st_div = divisor_i;
      assign st_rem = rem_i;
      assign st_dq  = dq_i;
    end else begin : g_next
      assign st_tag = g_stage[s-1].tag_r;
      assign st_div = g_stage[s-1].div_r;
      assign st_rem = g_stage[s-1].rem_r;
      assign st_dq  = g_stage[s-1].dq_r;
    end

    // Each step brings down one dividend bit and decides one quotient bit.
    always_comb begin
      logic [DW-1:0] rem;
      logic [QB-1:0] dq;
      logic [DW:0]   trial;
      logic          fits;
      rem   = st_rem;
      dq    = st_dq;
      trial = '0;
      fits  = 1'b0;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < QB) begin
          trial = {rem, dq[QB-1]};
          fits  = (trial >= {1'b0, st_div});
          dq    = {dq[QB-2:0], fits};
          rem   = fits ? DW'(trial - {1'b0, st_div}) : trial[DW-1:0];
        end
      end
      rem_nxt = rem;
      dq_nxt  = dq;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r <= '0;
      end else begin
        tag_r <= st_tag;
      end
    end

    always_ff @(posedge clk) begin
      div_r <= st_div;
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign tag_o  = g_stage[STAGES-1].tag_r;
  assign quot_o = g_stage[STAGES-1].dq_r;

endmodule

FILE: hw/rtl/vsc_shade.sv
// Segment decode, intensity weighting and exact scaling of the three color channels.
// Depends on vsc_pkg; takes the wavelength offset from vsc_divider.
module vsc_shade (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vsc_pkg::tag_t                    tag_i,
  input  logic [vsc_pkg::Q_BITS-1:0]       quot_i,
  output logic                             valid_o,
  output logic [vsc_pkg::CHANNEL_BITS-1:0] red_o,
  output logic [vsc_pkg::CHANNEL_BITS-1:0] green_o,
  output logic [vsc_pkg::CHANNEL_BITS-1:0] blue_o
);

  localparam int CB   = vsc_pkg::CHANNEL_BITS;
  localparam int FULL = 2**CB - 1;

  // Segment ends as offsets above 400 nm in 1/16 nm steps.
  localparam int LO_INT_END = 320;   // 420 nm
  localparam int SEG1_END   = 640;   // 440 nm
  localparam int SEG2_END   = 1440;  // 490 nm
  localparam int SEG3_END   = 1760;  // 510 nm
  localparam int SEG4_END   = 2880;  // 580 nm
  localparam int SEG5_END   = 3920;  // 645 nm

  localparam int INT_LO_BASE = 960;
  localparam int INT_HI_BASE = 2640;
  localparam int INT_SLOPE   = 7;

  // Scaled numerators stay below 2^17; the reciprocals are exact for them at this shift.
  localparam int X_W         = 17;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = X_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_1   = RECIP_W'(2**RECIP_SHIFT);
  localparam logic [RECIP_W-1:0] RECIP_5   = RECIP_W'((2**RECIP_SHIFT + 4) / 5);
  localparam logic [RECIP_W-1:0] RECIP_25  = RECIP_W'((2**RECIP_SHIFT + 24) / 25);
  localparam logic [RECIP_W-1:0] RECIP_35  = RECIP_W'((2**RECIP_SHIFT + 34) / 35);
  localparam logic [RECIP_W-1:0] RECIP_65  = RECIP_W'((2**RECIP_SHIFT + 64) / 65);
  localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'((2**RECIP_SHIFT + 124) / 125);
  localparam logic [RECIP_W-1:0] RECIP_275 = RECIP_W'((2**RECIP_SHIFT + 274) / 275);

  // Odd part of a channel's denominator; the power of two is shifted out beforehand.
  typedef enum logic [2:0] {
    DIV_1,
    DIV_5,
    DIV_25,
    DIV_35,
    DIV_65,
    DIV_125,
    DIV_275
  } div_sel_t;

  typedef struct packed {
    div_sel_t       sel;
    logic [X_W-1:0] x;
  } chan_term_t;

  function automatic logic [RECIP_W-1:0] recip(input div_sel_t sel);
    logic [RECIP_W-1:0] m;
    unique case (sel)
      DIV_1:   m = RECIP_1;
      DIV_5:   m = RECIP_5;
      DIV_25:  m = RECIP_25;
      DIV_35:  m = RECIP_35;
      DIV_65:  m = RECIP_65;
      DIV_125: m = RECIP_125;
      DIV_275: m = RECIP_275;
      default: m = RECIP_1;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] full_times(input logic [31:0] v);
    return (v << CB) - v;
  endfunction

  vsc_pkg::tag_t tag_r;
  chan_term_t    red_r, green_r, blue_r;
  chan_term_t    red_nxt, green_nxt, blue_nxt;
  logic          valid_r;
  logic [CB-1:0] red_r8, green_r8, blue_r8;
  logic [CB-1:0] red_ch_nxt, green_ch_nxt, blue_ch_nxt;

  // Prep stage: pick the segment and form each channel's numerator.
  always_comb begin
    logic [31:0] d32;
    logic [31:0] ib;
    logic [31:0] ih;
    logic [9:0]  fall1;
    logic [21:0] pr;
    d32   = 32'(quot_i);
    ib    = 32'(INT_LO_BASE) + 32'(INT_SLOPE) * d32;
    ih    = 32'(INT_HI_BASE) + 32'(INT_SLOPE) * (32'(vsc_pkg::WL_SPAN) - d32);
    fall1 = 10'(32'(SEG1_END) - d32);
    pr    = 22'(fall1) * 22'(ib[11:0]);

    red_nxt   = '{sel: DIV_1, x: '0};
    green_nxt = '{sel: DIV_1, x: '0};
    blue_nxt  = '{sel: DIV_1, x: '0};

    if (!tag_i.black) begin
      priority if (d32 < 32'(LO_INT_END)) begin
        // Violet ramp together with the rising intensity: 640*3200 = 2^14 * 125.
        red_nxt  = '{sel: DIV_125, x: X_W'(full_times(32'(pr)) >> 14)};
        blue_nxt = '{sel: DIV_25, x: X_W'(full_times(ib) >> 7)};
      end else if (d32 <= 32'(SEG1_END)) begin
        red_nxt  = '{sel: DIV_5, x: X_W'(full_times(32'(fall1)) >> 7)};
        blue_nxt = '{sel: DIV_1, x: X_W'(FULL)};
      end else if (d32 <= 32'(SEG2_END)) begin
        green_nxt = '{sel: DIV_25, x: X_W'(full_times(d32 - 32'(SEG1_END)) >> 5)};
        blue_nxt  = '{sel: DIV_1, x: X_W'(FULL)};
      end else if (d32 <= 32'(SEG3_END)) begin
        green_nxt = '{sel: DIV_1, x: X_W'(FULL)};
        blue_nxt  = '{sel: DIV_5, x: X_W'(full_times(32'(SEG3_END) - d32) >> 6)};
      end else if (d32 <= 32'(SEG4_END)) begin
        red_nxt   = '{sel: DIV_35, x: X_W'(full_times(d32 - 32'(SEG3_END)) >> 5)};
        green_nxt = '{sel: DIV_1, x: X_W'(FULL)};
      end else if (d32 <= 32'(SEG5_END)) begin
        red_nxt   = '{sel: DIV_1, x: X_W'(FULL)};
        green_nxt = '{sel: DIV_65, x: X_W'(full_times(32'(SEG5_END) - d32) >> 4)};
      end else begin
        // Deep red with the falling intensity: 8800 = 2^5 * 275.
        red_nxt = '{sel: DIV_275, x: X_W'(full_times(ih) >> 5)};
      end
    end
  end

  // Scale stage: divide by the odd denominator through its reciprocal.
  always_comb begin
    logic [PROD_W-1:0] pr_red;
    logic [PROD_W-1:0] pr_green;
    logic [PROD_W-1:0] pr_blue;
    pr_red       = PROD_W'(red_r.x) * PROD_W'(recip(red_r.sel));
    pr_green     = PROD_W'(green_r.x) * PROD_W'(recip(green_r.sel));
    pr_blue      = PROD_W'(blue_r.x) * PROD_W'(recip(blue_r.sel));
    red_ch_nxt   = pr_red[RECIP_SHIFT +: CB];
    green_ch_nxt = pr_green[RECIP_SHIFT +: CB];
    blue_ch_nxt  = pr_blue[RECIP_SHIFT +: CB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      tag_r   <= tag_i;
      valid_r <= tag_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
    red_r8   <= red_ch_nxt;
    green_r8 <= green_ch_nxt;
    blue_r8  <= blue_ch_nxt;
  end

  assign valid_o = valid_r;
  assign red_o   = red_r8;
  assign green_o = green_r8;
  assign blue_o  = blue_r8;

endmodule

FILE: hw/rtl/value_to_spectrum_color_unit.sv
// Top level of the value-to-spectrum color unit: config register, capture stage and pipeline.
// Depends on vsc_pkg, vsc_divider and vsc_shade.
//
// Usage:
// A signed level word is offered on in_level with start; it is taken at a rising edge
// where start is high and busy is low. busy is high only in the cycle after a reset edge,
// so after reset one word can be taken in every cycle.
// The result word (out_red, out_green, out_blue) shows for exactly one cycle, marked by
// out_valid, after its input has passed through the pipeline:
// one capture stage, DIV_STAGES stages of the restoring divider that works out the
// wavelength, one segment decode stage and one reciprocal scaling stage.
// Throughput is one word per cycle; the divider steps are spread over its stages so that
// nothing is shared between words. Results leave in input order.
// The user writes max_value (cfg_wr_en / cfg_wr_data) only while no word is in flight; the
// block does not enforce it. Each word carries its own copy of the divisor down the pipeline.
// Reset, synchronous and active low, empties the pipeline and sets max_value to 30.
// The receiver has no way to hold results off, so the pipeline never stalls.
// A negative level, a level above max_value, or max_value of zero gives black.
module value_to_spectrum_color_unit #(
  parameter int DIV_STAGES = vsc_pkg::DIV_STAGES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [vsc_pkg::LEVEL_W-1:0] in_level,
  output logic                              out_valid,
  output logic [vsc_pkg::CHANNEL_BITS-1:0]  out_red,
  output logic [vsc_pkg::CHANNEL_BITS-1:0]  out_green,
  output logic [vsc_pkg::CHANNEL_BITS-1:0]  out_blue,
  input  logic                              cfg_wr_en,
  input  logic [vsc_pkg::MAXV_W-1:0]        cfg_wr_data
);

  localparam int NW = vsc_pkg::DIVIDEND_W;
  localparam int QB = vsc_pkg::Q_BITS;

  logic [vsc_pkg::MAXV_W-1:0] max_value_r;
  logic                       busy_r;

  // Capture stage registers.
  vsc_pkg::tag_t              cap_tag_r;
  vsc_pkg::tag_t              cap_tag_nxt;
  logic [vsc_pkg::MAXV_W-1:0] cap_div_r;
  logic [vsc_pkg::MAXV_W-1:0] cap_rem_r;
  logic [vsc_pkg::MAXV_W-1:0] cap_rem_nxt;
  logic [QB-1:0]              cap_dq_r;
  logic [QB-1:0]              cap_dq_nxt;

  vsc_pkg::tag_t              div_tag;
  logic [QB-1:0]              div_quot;

  logic                       accept;
  logic [vsc_pkg::LEVEL_W-1:0] level_bits;
  logic [NW-1:0]              dividend;

  assign accept     = start && !busy_r;
  assign level_bits = $unsigned(in_level);

  // The dividend is the level times the full span. When the level does not exceed
  // max_value, its top bits already lie below the divisor, so they seed the remainder
  // and only the low bits have to be brought down by the divider.
  always_comb begin
    dividend          = NW'(level_bits) * NW'(vsc_pkg::WL_SPAN);
    cap_rem_nxt       = dividend[NW-1:QB];
    cap_dq_nxt        = dividend[QB-1:0];
    cap_tag_nxt.valid = accept;
    cap_tag_nxt.black = in_level[vsc_pkg::LEVEL_W-1]
                        || (max_value_r == '0)
                        || (level_bits > max_value_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= vsc_pkg::MAX_VALUE_RESET;
      busy_r      <= 1'b1;
      cap_tag_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_value_r <= cfg_wr_data;
      end
      busy_r    <= 1'b0;
      cap_tag_r <= cap_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_div_r <= max_value_r;
    cap_rem_r <= cap_rem_nxt;
    cap_dq_r  <= cap_dq_nxt;
  end

  vsc_divider #(
    .STAGES (DIV_STAGES)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (cap_tag_r),
    .divisor_i (cap_div_r),
    .rem_i     (cap_rem_r),
    .dq_i      (cap_dq_r),
    .tag_o     (div_tag),
    .quot_o    (div_quot)
  );

  // The shade stages end in the output register, so the ports come straight from it.
  vsc_shade u_shade (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_i   (div_tag),
    .quot_i  (div_quot),
    .valid_o (out_valid),
    .red_o   (out_red),
    .green_o (out_green),
    .blue_o  (out_blue)
  );

  assign busy = busy_r;

endmodule

FILE: hw/rtl/vsc_checker.sv
// Port-level checks of the value-to-spectrum color unit, with the bind that attaches them.
// Depends only on the top level's ports and its DIV_STAGES parameter.
module vsc_checker #(
  parameter int LAT = 7
) (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_level,
  input logic       out_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  localparam int CNT_W = $clog2(LAT + 1);

  logic [CNT_W-1:0] since_rst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_rst_r <= '0;
    end else if (since_rst_r < CNT_W'(LAT)) begin
      since_rst_r <= since_rst_r + 1'b1;
    end
  end

  // Every taken word yields exactly one result, and every result stems from a taken word.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (since_rst_r == CNT_W'(LAT)) |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result strobe does not match an input word taken LAT cycles earlier");

  // A negative level lies below the visible range and must come out black.
  a_negative_black: assert property (@(posedge clk) disable iff (!rst_n)
    ((since_rst_r == CNT_W'(LAT)) && out_valid && $past(in_level[7], LAT))
      |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("negative level did not give black");

  // No segment of the spectrum lights all three channels at once.
  a_two_channels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == 8'd0 || out_green == 8'd0 || out_blue == 8'd0))
    else $error("all three channels are lit");

  // The unit is ready again from the cycle after reset is released.
  a_ready_after_reset: assert property (@(posedge clk)
    rst_n |=> !busy)
    else $error("busy stays high outside reset");

endmodule

bind value_to_spectrum_color_unit vsc_checker #(
  .LAT (DIV_STAGES + 3)
) u_vsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_level  (in_level),
  .out_valid (out_valid),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);

FILE: bench/testbench.sv
// Self-checking bench for value_to_spectrum_color_unit: level words in, RGB words out.
// Depends on vsc_pkg and the RTL of the unit; a local color predictor works out each word.
`timescale 1ns / 1ps

module testbench;

  // Capture stage, divider stages, segment decode and scaling stage.
  localparam int LATENCY = vsc_pkg::DIV_STAGES + 3;

  // One color word as it leaves the unit.
  typedef struct packed {
    logic [vsc_pkg::CHANNEL_BITS-1:0] red;
    logic [vsc_pkg::CHANNEL_BITS-1:0] green;
    logic [vsc_pkg::CHANNEL_BITS-1:0] blue;
  } color_t;

  // Every input starts at a known value and is driven on the rising edge afterwards.
  logic                               clk         = 1'b0;
  logic                               rst_n       = 1'b0;
  logic                               start       = 1'b0;
  logic signed [vsc_pkg::LEVEL_W-1:0] in_level    = '0;
  logic                               cfg_wr_en   = 1'b0;
  logic [vsc_pkg::MAXV_W-1:0]         cfg_wr_data = '0;
  logic                               busy;
  logic                               out_valid;
  logic [vsc_pkg::CHANNEL_BITS-1:0]   out_red;
  logic [vsc_pkg::CHANNEL_BITS-1:0]   out_green;
  logic [vsc_pkg::CHANNEL_BITS-1:0]   out_blue;

  // Colors still owed by the unit, oldest first.
  color_t                     pending_colors[$];
  // Local copy of the max_value register, followed at each write edge.
  logic [vsc_pkg::MAXV_W-1:0] shadow_max_value;
  // Percentage of cycles in which the sender holds back before its next word.
  int                         sender_idle_pct = 0;
  int                         mismatch_count  = 0;

  value_to_spectrum_color_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_level   (in_level),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One channel: floor(full * fraction * intensity), with both factors kept as exact ratios.
  function automatic logic [vsc_pkg::CHANNEL_BITS-1:0] channel_level(
    input longint unsigned frac_num, input longint unsigned frac_den,
    input longint unsigned gain_num, input longint unsigned gain_den);
    longint unsigned full;
    full = (64'd1 << vsc_pkg::CHANNEL_BITS) - 1;
    return vsc_pkg::CHANNEL_BITS'((full * frac_num * gain_num) / (frac_den * gain_den));
  endfunction

  // Predicts the color of one level word. The wavelength is kept in 1/16 nm steps, so
  // 6400 stands for 400 nm and 11200 for 700 nm.
  function automatic color_t spectrum_color(input logic [vsc_pkg::LEVEL_W-1:0] level_bits,
                                            input logic [vsc_pkg::MAXV_W-1:0] max_value);
    longint unsigned wl;
    longint unsigned r_num, r_den, g_num, g_den, b_num, b_den, gain_num, gain_den;
    color_t c;
    c = '0;
    // A negative level, a level above max_value, or a zero max_value all give black.
    if (level_bits[vsc_pkg::LEVEL_W-1] || max_value == 0 || level_bits > max_value)
      return c;
    wl = 6400 + (64'd4800 * level_bits) / max_value;
    r_num = 0; r_den = 1; g_num = 0; g_den = 1; b_num = 0; b_den = 1;
    gain_num = 1; gain_den = 1;
    // The first segment holds both its ends; each later one holds only its upper end.
    if (wl <= 7040) begin
      r_num = 7040 - wl; r_den = 640; b_num = 1;
    end else if (wl <= 7840) begin
      g_num = wl - 7040; g_den = 800; b_num = 1;
    end else if (wl <= 8160) begin
      g_num = 1; b_num = 8160 - wl; b_den = 320;
    end else if (wl <= 9280) begin
      r_num = wl - 8160; r_den = 1120; g_num = 1;
    end else if (wl <= 10320) begin
      r_num = 1; g_num = 10320 - wl; g_den = 1040;
    end else begin
      r_num = 1;
    end
    // Intensity ramps up from 0.3 below 420 nm and back down to 0.3 above 645 nm.
    if (wl > 10320) begin
      gain_num = 2640 + 7 * (11200 - wl); gain_den = 8800;
    end else if (wl < 6720) begin
      gain_num = 960 + 7 * (wl - 6400); gain_den = 3200;
    end
    c.red   = channel_level(r_num, r_den, gain_num, gain_den);
    c.green = channel_level(g_num, g_den, gain_num, gain_den);
    c.blue  = channel_level(b_num, b_den, gain_num, gain_den);
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Prediction side: every word taken at an edge gets its color queued, worked out with
  // the register value in force at that edge. Config writes only happen while idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_max_value = vsc_pkg::MAX_VALUE_RESET;
    end else begin
      if (start === 1'b1 && busy === 1'b0)
        pending_colors = {pending_colors, spectrum_color(in_level, shadow_max_value)};
      if (cfg_wr_en)
        shadow_max_value = cfg_wr_data;
    end
  end

  // Checking side: a result word is on the ports for one cycle only and is taken at the
  // edge that ends it, so it is compared here against the oldest prediction.
  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("result word %0d/%0d/%0d with nothing expected",
                                  out_red, out_green, out_blue));
      end else begin
        want = pending_colors.pop_front();
        if (out_red !== want.red)
          report_mismatch($sformatf("red got %0d want %0d", out_red, want.red));
        if (out_green !== want.green)
          report_mismatch($sformatf("green got %0d want %0d", out_green, want.green));
        if (out_blue !== want.blue)
          report_mismatch($sformatf("blue got %0d want %0d", out_blue, want.blue));
      end
    end
  end

  // Offers one level word and returns at the edge where the unit takes it. Random idle
  // cycles go in front of the word, so the next call may keep start high without a gap.
  task automatic send_level(input logic signed [vsc_pkg::LEVEL_W-1:0] level);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_level <= level;
    do
      @(posedge clk);
    while (busy !== 1'b0);
  endtask

  // Stops sending and waits until every predicted color has come back. Each word gives
  // exactly one result, so an empty queue means the pipeline is empty too.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_max_value(input logic [vsc_pkg::MAXV_W-1:0] value);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Reset value of max_value (30): both ends, one inside, and both sides just out of range.
  task automatic test_reset_setting();
    send_level(8'sd0);
    send_level(8'sd15);
    send_level(8'sd30);
    send_level(8'sd31);
    send_level(-8'sd1);
  endtask

  // With max_value 120 one level step is exactly 2.5 nm, so each segment boundary and the
  // two intensity knees at 420 nm and 645 nm fall on whole levels.
  task automatic test_segment_edges();
    logic signed [vsc_pkg::LEVEL_W-1:0] edge_levels[$];
    edge_levels = {8'sd0, 8'sd8, 8'sd16, 8'sd17, 8'sd36, 8'sd44, 8'sd72, 8'sd98,
                   8'sd99, 8'sd120, 8'sd121, 8'sd127, -8'sd1, -8'sd128};
    write_max_value(8'd120);
    foreach (edge_levels[i])
      send_level(edge_levels[i]);
  endtask

  // Register extremes: zero gives black for every level, one spans the whole spectrum in a
  // single step, and 255 leaves the upper part of the spectrum out of reach.
  task automatic test_register_extremes();
    write_max_value(8'd0);
    send_level(8'sd0);
    send_level(8'sd1);
    write_max_value(8'd1);
    send_level(8'sd0);
    send_level(8'sd1);
    send_level(8'sd2);
    write_max_value(8'd255);
    send_level(8'sd127);
    send_level(-8'sd128);
  endtask

  // Random words under one idle pattern. The register changes every block of words, first
  // through 1, 255, 127 and 128 and then at random. Most levels fall inside 0..max_value,
  // where the spectrum is actually exercised; the rest cover the whole signed range.
  task automatic test_random_spectrum(input int idle_pct, input int word_count);
    logic [vsc_pkg::MAXV_W-1:0]  max_value;
    int                          top_level;
    logic [vsc_pkg::LEVEL_W-1:0] level_bits;
    sender_idle_pct = idle_pct;
    max_value       = vsc_pkg::MAX_VALUE_RESET;
    for (int n = 0; n < word_count; n++) begin
      if (n % 50 == 0) begin
        case (n / 50)
          0:       max_value = 8'd1;
          1:       max_value = 8'd255;
          2:       max_value = 8'd127;
          3:       max_value = 8'd128;
          default: max_value = ($urandom_range(0, 1) != 0)
                               ? vsc_pkg::MAXV_W'($urandom_range(1, 40))
                               : vsc_pkg::MAXV_W'($urandom_range(1, 255));
        endcase
        write_max_value(max_value);
      end
      top_level = (max_value > 127) ? 127 : max_value;
      if ($urandom_range(0, 99) < 80)
        level_bits = vsc_pkg::LEVEL_W'($urandom_range(0, top_level));
      else
        level_bits = vsc_pkg::LEVEL_W'($urandom_range(0, 255));
      send_level(level_bits);
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_setting();
    test_segment_edges();
    test_register_extremes();
    test_random_spectrum(0, 400);
    test_random_spectrum(86, 350);
    test_random_spectrum(20, 400);

    drain_pipeline();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // A correct run needs well under a tenth of this, even with the long sender gaps.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
